@@ src/rbfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfs_pkg
// Shared types and constants for the ring buffer FIFO with skip.
// ----------------------------------------------------------------------------
package rbfs_pkg;

	localparam int DATA_W   = 32;
	localparam int OPCODE_W = 3;
	localparam int SKIP_W   = 5;
	localparam int CFG_W    = 5;
	localparam int COUNT_W  = 4;
	localparam int STATUS_W = 2;
	localparam int ARITH_W  = CFG_W + 1;

	localparam int DEPTH_DEFAULT = 16;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic [OPCODE_W-1:0] {
		OP_QUERY = 3'd0,
		OP_PUSH  = 3'd1,
		OP_POP   = 3'd2,
		OP_SKIP  = 3'd3,
		OP_CLEAR = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_CLAMPED = 2'd3
	} status_t;

endpackage

@@ src/rbfs_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfs_in_if
// Input channel: valid/ready handshake carrying one FIFO command.
// ----------------------------------------------------------------------------
interface rbfs_in_if;
	logic                             valid;
	logic                             ready;
	logic [rbfs_pkg::OPCODE_W-1:0]    opcode;
	logic [rbfs_pkg::DATA_W-1:0]      push_data;
	logic [rbfs_pkg::SKIP_W-1:0]      skip_count;

	modport source (output valid, output opcode, output push_data, output skip_count,
		input ready);
	modport sink (input valid, input opcode, input push_data, input skip_count,
		output ready);
endinterface

@@ src/rbfs_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfs_out_if
// Result channel: valid/ready handshake carrying head entry and occupancy.
// ----------------------------------------------------------------------------
interface rbfs_out_if;
	logic                             valid;
	logic                             ready;
	logic [rbfs_pkg::DATA_W-1:0]      head_data;
	logic [rbfs_pkg::COUNT_W-1:0]     fill_count;
	logic [rbfs_pkg::COUNT_W-1:0]     free_count;
	logic [rbfs_pkg::COUNT_W-1:0]     contiguous_count;
	logic                             is_empty;
	logic                             is_full;
	logic [rbfs_pkg::STATUS_W-1:0]    status;

	modport source (output valid, output head_data, output fill_count, output free_count,
		output contiguous_count, output is_empty, output is_full, output status,
		input ready);
	modport sink (input valid, input head_data, input fill_count, input free_count,
		input contiguous_count, input is_empty, input is_full, input status,
		output ready);
endinterface

@@ src/ring_buffer_fifo_with_skip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_fifo_with_skip
// Ring buffer FIFO with query, push, pop, multi-entry skip and clear commands.
// ----------------------------------------------------------------------------
// One command is taken per clock unless the result side stalls, set by a single
// pass through the pointer arithmetic between the input register and the result
// register. A result passes through the input register, then the result
// register, before it is presented.
// The ring size is the configuration register, clamped to [2, min(DEPTH, 31)],
// with one slot kept empty; writing it clears both pointers. The head entry is
// held in a register refreshed from the store every cycle, with a bypass for a
// push into an empty ring. Results report the head entry before the command
// (zero when empty) and the occupancy after it.
module ring_buffer_fifo_with_skip #(
	parameter int DEPTH = rbfs_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rbfs_pkg::CFG_W-1:0]    cfg_wr_data,
	rbfs_in_if.sink                       item,
	rbfs_out_if.source                    result
);
	import rbfs_pkg::*;

	localparam int RING_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam int PTR_W    = $clog2(RING_MAX);
	localparam logic [ARITH_W-1:0] RING_MAX_A = ARITH_W'(RING_MAX);
	localparam logic [ARITH_W-1:0] RING_MIN_A = ARITH_W'(2);

	logic [CFG_W-1:0]     cfg_q;
	logic [PTR_W-1:0]     rd_q;
	logic [PTR_W-1:0]     wr_q;
	logic [DATA_W-1:0]    mem [RING_MAX];
	logic [DATA_W-1:0]    head_q;

	logic                 v_s1;
	logic [OPCODE_W-1:0]  opcode_s1;
	logic [DATA_W-1:0]    push_data_s1;
	logic [SKIP_W-1:0]    skip_count_s1;

	logic                 v_s2;
	logic [DATA_W-1:0]    head_s2;
	logic [COUNT_W-1:0]   fill_s2;
	logic [COUNT_W-1:0]   free_s2;
	logic [COUNT_W-1:0]   cont_s2;
	logic                 empty_s2;
	logic                 full_s2;
	status_t              status_s2;

	logic                 fire;
	logic                 push_ok;
	logic [ARITH_W-1:0]   n_c;
	logic [ARITH_W-1:0]   cfg_e;
	logic [ARITH_W-1:0]   rd_e;
	logic [ARITH_W-1:0]   wr_e;
	logic [ARITH_W-1:0]   cnt_pre;
	logic [ARITH_W-1:0]   rd_inc;
	logic [ARITH_W-1:0]   wr_inc;
	logic [ARITH_W-1:0]   skip_e;
	logic [ARITH_W-1:0]   skip_amt;
	logic [ARITH_W-1:0]   rd_skip;
	logic [ARITH_W-1:0]   rd_nx;
	logic [ARITH_W-1:0]   wr_nx;
	logic [ARITH_W-1:0]   cnt_post;
	logic [ARITH_W-1:0]   free_post;
	logic [ARITH_W-1:0]   cont_post;
	logic [PTR_W-1:0]     rd_rd_addr;
	status_t              status_c;

	assign fire       = v_s1 && (!v_s2 || result.ready);
	assign item.ready = !v_s1 || fire;

	// ring size and pre-step occupancy
	assign cfg_e = ARITH_W'(cfg_q);
	always_comb begin
		priority if (cfg_e < RING_MIN_A) begin
			n_c = RING_MIN_A;
		end else if (cfg_e > RING_MAX_A) begin
			n_c = RING_MAX_A;
		end else begin
			n_c = cfg_e;
		end
	end

	assign rd_e    = ARITH_W'(rd_q);
	assign wr_e    = ARITH_W'(wr_q);
	assign cnt_pre = (wr_e >= rd_e) ? (wr_e - rd_e) : (wr_e + n_c - rd_e);

	assign rd_inc   = ((rd_e + ARITH_W'(1)) == n_c) ? '0 : (rd_e + ARITH_W'(1));
	assign wr_inc   = ((wr_e + ARITH_W'(1)) == n_c) ? '0 : (wr_e + ARITH_W'(1));
	assign skip_e   = ARITH_W'(skip_count_s1);
	assign skip_amt = (skip_e > cnt_pre) ? cnt_pre : skip_e;
	assign rd_skip  = ((rd_e + skip_amt) >= n_c) ? (rd_e + skip_amt - n_c)
		: (rd_e + skip_amt);

	always_comb begin
		rd_nx    = rd_e;
		wr_nx    = wr_e;
		push_ok  = 1'b0;
		status_c = ST_OK;
		if (fire) begin
			unique case (opcode_s1)
				OP_PUSH: begin
					if (cnt_pre == n_c - ARITH_W'(1)) begin
						status_c = ST_FULL;
					end else begin
						push_ok = 1'b1;
						wr_nx   = wr_inc;
					end
				end
				OP_POP: begin
					if (cnt_pre == '0) begin
						status_c = ST_EMPTY;
					end else begin
						rd_nx = rd_inc;
					end
				end
				OP_SKIP: begin
					if (skip_e > cnt_pre) begin
						status_c = ST_CLAMPED;
					end
					rd_nx = rd_skip;
				end
				OP_CLEAR: begin
					rd_nx = '0;
					wr_nx = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// post-step figures
	assign cnt_post  = (wr_nx >= rd_nx) ? (wr_nx - rd_nx) : (wr_nx + n_c - rd_nx);
	assign free_post = n_c - ARITH_W'(1) - cnt_post;
	always_comb begin
		priority if (wr_nx < rd_nx) begin
			cont_post = n_c - rd_nx;
		end else if (wr_nx > rd_nx) begin
			cont_post = wr_nx - rd_nx;
		end else begin
			cont_post = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
			rd_q  <= '0;
			wr_q  <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
				rd_q  <= '0;
				wr_q  <= '0;
			end else begin
				rd_q <= rd_nx[PTR_W-1:0];
				wr_q <= wr_nx[PTR_W-1:0];
			end
			if (item.ready) begin
				v_s1 <= item.valid;
			end
			if (fire) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1     <= item.opcode;
			push_data_s1  <= item.push_data;
			skip_count_s1 <= item.skip_count;
		end
	end

	// entry store and head register
	assign rd_rd_addr = cfg_wr_en ? '0 : rd_nx[PTR_W-1:0];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_q] <= push_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok && (wr_q == rd_rd_addr)) begin
			head_q <= push_data_s1;
		end else begin
			head_q <= mem[rd_rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			head_s2   <= (cnt_pre != '0) ? head_q : '0;
			fill_s2   <= cnt_post[COUNT_W-1:0];
			free_s2   <= free_post[COUNT_W-1:0];
			cont_s2   <= cont_post[COUNT_W-1:0];
			empty_s2  <= (cnt_post == '0);
			full_s2   <= (cnt_post == n_c - ARITH_W'(1));
			status_s2 <= status_c;
		end
	end

	assign result.valid            = v_s2;
	assign result.head_data        = head_s2;
	assign result.fill_count       = fill_s2;
	assign result.free_count       = free_s2;
	assign result.contiguous_count = cont_s2;
	assign result.is_empty         = empty_s2;
	assign result.is_full          = full_s2;
	assign result.status           = status_s2;

`ifndef NO_ASSERTIONS
	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_e < n_c) && (wr_e < n_c))
		else $error("pointer outside ring");

	a_not_empty_and_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.is_empty && result.is_full))
		else $error("result both empty and full");

	a_empty_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.is_empty) |-> (result.contiguous_count == '0))
		else $error("empty ring reports readable run");

	a_push_moves_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !cfg_wr_en) |=> (rd_q != wr_q))
		else $error("accepted push left ring empty");
`endif

endmodule
